FILE: hdl/pdss_pkg.sv
`default_nettype none

package pdss_pkg;

	// Field widths fixed by the item formats
	localparam int unsigned CHAN_W   = 4;
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned ENTRY_W  = 6;
	localparam int unsigned SCALED_W = 10;
	localparam int unsigned HOLD_W   = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;

	// Scaling constants: value = stable * SCALE_MUL / 2**SCALE_SHIFT - SCALE_OFFSET
	localparam int unsigned SCALE_MUL_W  = 11;
	localparam int unsigned PRODUCT_W    = SAMPLE_W + SCALE_MUL_W;
	localparam int unsigned SCALE_SHIFT  = 12;
	localparam int unsigned QUOT_W       = PRODUCT_W - SCALE_SHIFT;
	localparam logic [SCALE_MUL_W-1:0] SCALE_MUL    = 11'd1100;
	localparam logic [QUOT_W-1:0]      SCALE_OFFSET = 11'd50;
	localparam logic [QUOT_W-1:0]      SCALE_LIMIT  = 11'd1000;

	// Register reset values
	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd16;
	localparam logic [HOLD_W-1:0]   HOLD_RESET      = 8'd50;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_HOLD      = 2'd1
	} cfg_reg_t;

	// Input operation codes
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_ASSIGN = 1'b1
	} op_t;

	typedef struct packed {
		logic                operation;
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] raw_sample;
		logic [ENTRY_W-1:0]  target_entry;
		logic                target_valid;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0]   out_channel;
		logic [SCALED_W-1:0] scaled_value;
		logic                update_valid;
		logic [ENTRY_W-1:0]  update_entry;
	} out_item_t;

	// Classified item passed from front to back through the queue
	typedef struct packed {
		op_t                 op;
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] raw_sample;
		logic                bind_valid;
		logic [ENTRY_W-1:0]  bind_entry;
	} work_item_t;

	// Queue status seen by the front
	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_stat_t;

	// Scale a stabilized sample and clamp to the output range
	function automatic logic [SCALED_W-1:0] scale_value(input logic [SAMPLE_W-1:0] stable);
		logic [PRODUCT_W-1:0] product;
		logic [QUOT_W-1:0]    quot;
		logic [QUOT_W-1:0]    shifted;
		logic [QUOT_W-1:0]    clamped;
		product = PRODUCT_W'(stable) * PRODUCT_W'(SCALE_MUL);
		quot    = product[PRODUCT_W-1:SCALE_SHIFT];
		if (quot < SCALE_OFFSET) begin
			shifted = '0;
		end else begin
			shifted = quot - SCALE_OFFSET;
		end
		clamped = (shifted > SCALE_LIMIT) ? SCALE_LIMIT : shifted;
		return clamped[SCALED_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/pdss_front.sv
`default_nettype none

module pdss_front import pdss_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = 16,
	parameter int unsigned NUM_ENTRIES  = 64
) (
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_item,
	input  wire queue_stat_t q_stat,
	output logic             push,
	output work_item_t       push_item
);

	localparam int unsigned CMP_CH_W = CHAN_W + 7;
	localparam int unsigned CMP_EN_W = ENTRY_W + 9;

	logic chan_ok;
	logic entry_ok;
	logic accept;

	// Stall only while the queue has no free slot
	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;

	// Drop items for channels that do not exist
	assign chan_ok  = CMP_CH_W'(in_item.channel) < CMP_CH_W'(NUM_CHANNELS);
	assign entry_ok = CMP_EN_W'(in_item.target_entry) < CMP_EN_W'(NUM_ENTRIES);

	assign push = accept && chan_ok;

	// Classify: an out-of-range entry or a clear target acts as an unbind
	always_comb begin
		push_item.op         = op_t'(in_item.operation);
		push_item.channel    = in_item.channel;
		push_item.raw_sample = in_item.raw_sample;
		push_item.bind_valid = in_item.target_valid && entry_ok;
		push_item.bind_entry = push_item.bind_valid ? in_item.target_entry : '0;
	end

endmodule

`default_nettype wire

FILE: hdl/pdss_queue.sv
`default_nettype none

module pdss_queue import pdss_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire work_item_t push_item,
	input  wire logic       pop,
	output queue_stat_t     q_stat,
	output work_item_t      head_item
);

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = 1;
	localparam int unsigned CNT_W = 2;

	work_item_t         slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign q_stat.full      = (count_q == CNT_W'(DEPTH));
	assign q_stat.not_empty = (count_q != '0);
	assign head_item        = slot_q[rd_ptr_q];
	assign do_pop           = pop && q_stat.not_empty;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/pdss_back.sv
`default_nettype none

module pdss_back import pdss_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  head_valid,
	input  wire work_item_t            head_item,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_item
);

	// Channel field is four bits, so at most sixteen slots are reachable
	localparam int unsigned NUM_SLOTS = (NUM_CHANNELS < 16) ? NUM_CHANNELS : 16;
	localparam int unsigned SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [SAMPLE_W-1:0] threshold_q;
	logic [HOLD_W-1:0]   hold_ticks_q;

	logic [SAMPLE_W-1:0] stable_q   [NUM_SLOTS];
	logic [HOLD_W-1:0]   hold_q     [NUM_SLOTS];
	logic [SCALED_W-1:0] prev_q     [NUM_SLOTS];
	logic                changed_q  [NUM_SLOTS];
	logic [ENTRY_W-1:0]  entry_q    [NUM_SLOTS];
	logic                bound_q    [NUM_SLOTS];

	logic                out_valid_q;
	out_item_t           out_item_q;

	logic [SLOT_W-1:0]   idx;
	logic [SAMPLE_W-1:0] st_cur;
	logic [SAMPLE_W-1:0] diff;
	logic [HOLD_W-1:0]   hold_load;
	logic                hold_nz;
	logic [SAMPLE_W-1:0] st_next;
	logic [SCALED_W-1:0] scaled;
	logic                chg;
	logic                upd;
	logic [HOLD_W-1:0]   hold_next;
	out_item_t           res;

	// Take the head when the output register is free or drains this cycle
	assign pop       = head_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign idx    = SLOT_W'(head_item.channel);
	assign st_cur = stable_q[idx];

	// Deadband check, hold counter, scaling and update decision
	always_comb begin
		diff      = (head_item.raw_sample > st_cur) ? (head_item.raw_sample - st_cur)
		                                            : (st_cur - head_item.raw_sample);
		hold_load = (diff > threshold_q) ? hold_ticks_q : hold_q[idx];
		hold_nz   = (hold_load != '0);
		st_next   = hold_nz ? head_item.raw_sample : st_cur;
		scaled    = scale_value(st_next);
		chg       = changed_q[idx] || (hold_nz && (scaled != prev_q[idx]));
		upd       = chg && bound_q[idx];
		hold_next = hold_nz ? (hold_load - 1'b1) : '0;

		res.out_channel = head_item.channel;
		if (head_item.op == OP_SAMPLE) begin
			res.scaled_value = scaled;
			res.update_valid = upd;
			res.update_entry = upd ? entry_q[idx] : '0;
		end else begin
			// Previous scaled value always equals the scaled stabilized value
			res.scaled_value = prev_q[idx];
			res.update_valid = 1'b0;
			res.update_entry = '0;
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RESET;
			hold_ticks_q <= HOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q  <= cfg_data;
				REG_HOLD:      hold_ticks_q <= cfg_data[HOLD_W-1:0];
				default:       ;
			endcase
		end
	end

	// Update per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				stable_q[i]  <= '0;
				hold_q[i]    <= '0;
				prev_q[i]    <= '0;
				changed_q[i] <= 1'b1;
				entry_q[i]   <= '0;
				bound_q[i]   <= 1'b0;
			end
		end else if (pop) begin
			if (head_item.op == OP_SAMPLE) begin
				stable_q[idx]  <= st_next;
				hold_q[idx]    <= hold_next;
				prev_q[idx]    <= scaled;
				changed_q[idx] <= chg && !upd;
			end else begin
				entry_q[idx]   <= head_item.bind_entry;
				bound_q[idx]   <= head_item.bind_valid;
				changed_q[idx] <= 1'b1;
			end
		end
	end

	// Output register: load on pop, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q <= res;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/pot_deadband_stabilize_scale_unit.sv
// Channel  | Signals                                   | Direction | Accepted when
// ---------+-------------------------------------------+-----------+-------------------
// input    | in_valid, in_stall, in_item               | in        | in_valid & !in_stall
// result   | out_valid, out_stall, out_item            | out       | out_valid & !out_stall
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | cfg_valid & cfg_ready
//
// One item per cycle unless the result side stalls; an accepted item goes to the queue,
// then to the output register. The back unit reads, updates and writes a channel's state
// in the cycle it pops the item, so consecutive items on the same channel need no spacing.
// Items for channels beyond NUM_CHANNELS are dropped and produce no result.
// Reset sets the state of every channel at once; no clearing pass is needed.
// in_stall rises only when the two-entry queue is full, i.e. after the result side stalls.
`default_nettype none

module pot_deadband_stabilize_scale_unit import pdss_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = 16,
	parameter int unsigned NUM_ENTRIES  = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_item,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	queue_stat_t q_stat;
	logic        push;
	work_item_t  push_item;
	logic        pop;
	work_item_t  head_item;

	assign cfg_ready = 1'b1;

	pdss_front #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_stat   (q_stat),
		.push     (push),
		.push_item(push_item)
	);

	pdss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.q_stat   (q_stat),
		.head_item(head_item)
	);

	pdss_back #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head_valid(q_stat.not_empty),
		.head_item (head_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

FILE: hdl/pdss_checker.sv
`default_nettype none

module pdss_checker import pdss_pkg::*; #(
	parameter int unsigned NUM_ENTRIES = 64
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire in_item_t              in_item,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire out_item_t             out_item
);

	localparam int unsigned CMP_EN_W = ENTRY_W + 9;

	// Stalled input item holds its value
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_item))
		else $error("input item changed while stalled");

	// Stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Scaled value stays within the clamp range
	a_scaled_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.scaled_value <= SCALED_W'(1000))
		else $error("scaled value above 1000");

	// Without an update the entry field is zero
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.update_valid |-> out_item.update_entry == '0)
		else $error("update entry set without update");

	// An update only targets an existing entry
	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.update_valid
		|-> CMP_EN_W'(out_item.update_entry) < CMP_EN_W'(NUM_ENTRIES))
		else $error("update entry out of range");

endmodule

bind pot_deadband_stabilize_scale_unit pdss_checker #(
	.NUM_ENTRIES(NUM_ENTRIES)
) u_pdss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_item  (in_item),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_item (out_item)
);

`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

import pdss_pkg::*;

// Track per-channel filter state, predict each reading and check readings in order
class pot_filter_scoreboard;
	localparam int NUM_POTS         = 16;
	localparam int NUM_SLOTS        = 64;
	localparam int unsigned SCALE_NUM   = 1100;
	localparam int unsigned SCALE_DEN   = 4096;
	localparam int unsigned SCALE_BIAS  = 50;
	localparam int unsigned SCALE_TOP   = 1000;
	localparam int MAX_PRINTED      = 30;

	logic [SAMPLE_W-1:0] threshold;
	logic [HOLD_W-1:0]   hold_reload;

	logic [SAMPLE_W-1:0] stable [NUM_POTS];
	logic [HOLD_W-1:0]   hold_left [NUM_POTS];
	logic [SCALED_W-1:0] last_scaled [NUM_POTS];
	bit                  dirty [NUM_POTS];
	logic [ENTRY_W-1:0]  entry_of [NUM_POTS];
	bit                  bound [NUM_POTS];

	out_item_t expected_readings [$];

	int mismatches;
	int readings_checked;
	int updates_seen;
	int assigns_noted;

	function new();
		threshold   = THRESHOLD_RESET;
		hold_reload = HOLD_RESET;
		for (int c = 0; c < NUM_POTS; c++) begin
			stable[c]      = '0;
			hold_left[c]   = '0;
			last_scaled[c] = '0;
			dirty[c]       = 1'b1;
			entry_of[c]    = '0;
			bound[c]       = 1'b0;
		end
	endfunction

	// Scale a stabilized sample to 0..1000
	function logic [SCALED_W-1:0] permille_of(logic [SAMPLE_W-1:0] v);
		int unsigned q;
		q = (int'(v) * SCALE_NUM) / SCALE_DEN;
		if (q < SCALE_BIAS) return '0;
		q = q - SCALE_BIAS;
		if (q > SCALE_TOP) q = SCALE_TOP;
		return q[SCALED_W-1:0];
	endfunction

	function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_THRESHOLD: threshold = value[SAMPLE_W-1:0];
			REG_HOLD:      hold_reload = value[HOLD_W-1:0];
			default: ;
		endcase
	endfunction

	// Advance the channel state for one accepted item and queue its reading
	function void note_item(in_item_t it);
		logic [SAMPLE_W-1:0] diff;
		out_item_t r;
		int c;
		c = int'(it.channel);
		if (c >= NUM_POTS) return;
		r = '0;
		r.out_channel = it.channel;
		if (op_t'(it.operation) == OP_SAMPLE) begin
			diff = (it.raw_sample > stable[c]) ? it.raw_sample - stable[c]
				: stable[c] - it.raw_sample;
			if (diff > threshold) hold_left[c] = hold_reload;
			if (hold_left[c] != 0) stable[c] = it.raw_sample;
			r.scaled_value = permille_of(stable[c]);
			if (r.scaled_value != last_scaled[c] && hold_left[c] != 0) dirty[c] = 1'b1;
			if (hold_left[c] != 0) hold_left[c] = hold_left[c] - 1'b1;
			last_scaled[c] = r.scaled_value;
			if (dirty[c] && bound[c]) begin
				r.update_valid = 1'b1;
				r.update_entry = entry_of[c];
				dirty[c] = 1'b0;
			end
		end else begin
			assigns_noted++;
			if (it.target_valid && int'(it.target_entry) < NUM_SLOTS) begin
				bound[c]    = 1'b1;
				entry_of[c] = it.target_entry;
			end else begin
				bound[c]    = 1'b0;
				entry_of[c] = '0;
			end
			r.scaled_value = permille_of(stable[c]);
			dirty[c] = 1'b1;
		end
		expected_readings.push_back(r);
	endfunction

	task report_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, what);
	endtask

	// Compare a reading field by field against the oldest prediction
	task check_reading(out_item_t got);
		out_item_t want;
		if (expected_readings.size() == 0) begin
			report_mismatch($sformatf("reading with nothing pending, channel %0d",
				got.out_channel));
			return;
		end
		want = expected_readings.pop_front();
		readings_checked++;
		if (want.update_valid) updates_seen++;
		if (got.out_channel !== want.out_channel)
			report_mismatch($sformatf("out_channel %0d, want %0d",
				got.out_channel, want.out_channel));
		if (got.scaled_value !== want.scaled_value)
			report_mismatch($sformatf("channel %0d scaled_value %0d, want %0d",
				want.out_channel, got.scaled_value, want.scaled_value));
		if (got.update_valid !== want.update_valid)
			report_mismatch($sformatf("channel %0d update_valid %0b, want %0b",
				want.out_channel, got.update_valid, want.update_valid));
		if (got.update_entry !== want.update_entry)
			report_mismatch($sformatf("channel %0d update_entry %0d, want %0d",
				want.out_channel, got.update_entry, want.update_entry));
	endtask
endclass

module testbench;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int SETTLE_CYCLES    = 6;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pot_filter_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;
	int cycle_count;
	int n_items_sent;
	int n_cfg_writes;
	int n_long_holds;
	int knob_pos [16];

	pot_deadband_stabilize_scale_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d readings still pending",
				cycle_count, sb.expected_readings.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_item(in_item);
		if (arst_n && out_valid && !out_stall) sb.check_reading(out_item);
	end

	// Drive the result-side stall; hold it off for a long stretch on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				n_long_holds++;
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic in_item_t pot_item(op_t op, int ch, int raw, int entry, bit tv);
		in_item_t it;
		it.operation    = op;
		it.channel      = ch[CHAN_W-1:0];
		it.raw_sample   = raw[SAMPLE_W-1:0];
		it.target_entry = entry[ENTRY_W-1:0];
		it.target_valid = tv;
		return it;
	endfunction

	// Build a random item: mostly a knob drifting with jitter, some jumps and rebinds
	function automatic in_item_t make_knob_item();
		in_item_t it;
		int roll;
		int c;
		int raw;
		int span;
		it.operation    = OP_SAMPLE;
		it.channel      = CHAN_W'($urandom_range(15));
		it.raw_sample   = SAMPLE_W'($urandom_range(4095));
		it.target_entry = ENTRY_W'($urandom_range(63));
		it.target_valid = 1'($urandom_range(1));
		c = int'(it.channel);
		roll = $urandom_range(99);
		if (roll < 12) begin
			it.operation = OP_ASSIGN;
			it.target_valid = ($urandom_range(99) < 80);
		end else if (roll < 72) begin
			span = int'(sb.threshold) + 3;
			if (span > 300) span = 300;
			raw = knob_pos[c] + int'($urandom_range(2 * span)) - span;
			if (raw < 0) raw = 0;
			if (raw > 4095) raw = 4095;
			it.raw_sample = raw[SAMPLE_W-1:0];
		end else if (roll < 90) begin
			knob_pos[c] = $urandom_range(4095);
			it.raw_sample = knob_pos[c][SAMPLE_W-1:0];
		end else if (roll < 95) begin
			case ($urandom_range(5))
				0: it.raw_sample = 12'd0;
				1: it.raw_sample = 12'd4095;
				2: it.raw_sample = 12'd186;
				3: it.raw_sample = 12'd187;
				4: it.raw_sample = 12'd3909;
				default: it.raw_sample = 12'd3910;
			endcase
		end
		return it;
	endfunction

	// Offer one item, called at a falling edge; return at the falling edge after acceptance
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_register(idx, value);
		n_cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Set both registers; the hold value carries random upper bits that must be ignored
	task automatic set_filter(input int thr, input int hold);
		write_reg(REG_THRESHOLD, thr[CFG_DATA_W-1:0]);
		write_reg(REG_HOLD, {4'($urandom), hold[HOLD_W-1:0]});
	endtask

	// Drop valid, wait for every pending reading, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n_items) send_item(make_knob_item());
		settle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		foreach (knob_pos[i]) knob_pos[i] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset settings, bind/unbind, scale edges, threshold boundary
		send_item(pot_item(OP_SAMPLE, 3, 0, 0, 0));
		send_item(pot_item(OP_ASSIGN, 0, 0, 0, 1));
		send_item(pot_item(OP_SAMPLE, 0, 4095, 0, 0));
		send_item(pot_item(OP_SAMPLE, 0, 4090, 0, 0));
		send_item(pot_item(OP_SAMPLE, 0, 3910, 0, 0));
		send_item(pot_item(OP_SAMPLE, 0, 3909, 0, 0));
		send_item(pot_item(OP_ASSIGN, 15, 4095, 63, 1));
		send_item(pot_item(OP_SAMPLE, 15, 186, 63, 1));
		send_item(pot_item(OP_SAMPLE, 15, 187, 0, 0));
		send_item(pot_item(OP_SAMPLE, 15, 2048, 0, 0));
		send_item(pot_item(OP_ASSIGN, 15, 0, 63, 0));
		send_item(pot_item(OP_SAMPLE, 15, 100, 0, 0));
		send_item(pot_item(OP_ASSIGN, 9, 0, 21, 0));
		send_item(pot_item(OP_SAMPLE, 7, 16, 0, 0));
		send_item(pot_item(OP_SAMPLE, 7, 17, 0, 0));
		settle();

		// Zero hold time: the stabilized value never follows
		set_filter(0, 0);
		send_item(pot_item(OP_SAMPLE, 5, 4095, 0, 0));
		send_item(pot_item(OP_ASSIGN, 5, 0, 42, 1));
		send_item(pot_item(OP_SAMPLE, 5, 2000, 0, 0));
		settle();

		// Unused register indexes, then widest deadband and longest hold
		write_reg(REG_SPARE_A, 12'($urandom));
		write_reg(REG_SPARE_B, 12'($urandom));
		set_filter(4095, 255);
		send_item(pot_item(OP_SAMPLE, 0, 0, 0, 0));
		send_item(pot_item(OP_SAMPLE, 1, 4095, 0, 0));
		send_item(pot_item(OP_ASSIGN, 1, 0, 63, 1));
		send_item(pot_item(OP_SAMPLE, 1, 4095, 0, 0));
		settle();

		// Single-sample hold
		set_filter(0, 1);
		send_item(pot_item(OP_SAMPLE, 1, 1, 0, 0));
		send_item(pot_item(OP_SAMPLE, 1, 1, 0, 0));
		settle();

		// Random phases across settings, idling and stall patterns
		set_filter(16, 50);
		run_phase(250, 0, 0);
		set_filter(0, 255);
		run_phase(250, 46, 0);
		set_filter(4095, 0);
		run_phase(150, 0, 46);
		set_filter($urandom_range(64), 1);
		run_phase(250, 26, 26);
		set_filter(40, 3);
		hold_request = 1'b1;
		run_phase(250, 0, 0);
		set_filter($urandom_range(200), $urandom_range(255));
		run_phase(200, 26, 26);
		set_filter($urandom_range(32), $urandom_range(2, 8));
		run_phase(200, 46, 46);

		$display("Covered %0d items (%0d assigns), %0d readings checked, %0d entry updates,",
			n_items_sent, sb.assigns_noted, sb.readings_checked, sb.updates_seen);
		$display("  %0d register writes and %0d long output hold-offs.",
			n_cfg_writes, n_long_holds);
		if (sb.expected_readings.size() != 0)
			sb.report_mismatch("predicted readings never arrived");
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

`default_nettype wire
